// ----- design/sdq_pkg.sv -----
// ----------------------------------------------------------------------------
// sdq_pkg: shared types and codes for the sleep deadline queue
// Transfer payloads, queue entry layout and result kind codes.
// ----------------------------------------------------------------------------
package sdq_pkg;

  localparam int TICK_W    = 63;
  localparam int ID_W      = 8;
  localparam int DUR_W     = 32;
  localparam int KIND_W    = 3;
  localparam int MAX_WAKES = 16;
  localparam int WAKE_W    = $clog2(MAX_WAKES + 1);

  // Request function codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_SLEEP = 1'b1;

  // Result kind codes
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WOKEN    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NO_WAKE  = 3'd4;

  typedef struct packed {
    logic                    func;
    logic [ID_W-1:0]         sleeper_id;
    logic signed [DUR_W-1:0] sleep_ticks;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   woken_id;
    logic [TICK_W-1:0] tick_count;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] wake_time;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

// ----- design/sdq_store.sv -----
// ----------------------------------------------------------------------------
// sdq_store: sleeper entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdq_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  sdq_pkg::entry_t wr_entry,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output sdq_pkg::entry_t rd_entry
);

  sdq_pkg::entry_t mem [DEPTH];
  sdq_pkg::entry_t rd_entry_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Read one entry, hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

// ----- design/sleep_deadline_queue.sv -----
// Sequence: an ignored or full request goes straight to the final step and the
//   output register; an accepted request reads and shifts back each queued entry with a later
//   wake time, then writes; a tick pops front entries while they are due, then reports.
// Throughput: one item at a time, ready again as the final result enters the
//   output register; one read port and one 63-bit compare set the step.
// Reset: count, queue occupancy and control clear at once; no clearing pass.
// ----------------------------------------------------------------------------
// sleep_deadline_queue: sorted deadline timer queue
// Keeps a tick count and a circular queue of sleepers sorted by wake time.
// ----------------------------------------------------------------------------
module sleep_deadline_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sdq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sdq_pkg::out_item_t out_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = sdq_pkg::TICK_W;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_RD  = 6'b000010,
    S_INS_CMP = 6'b000100,
    S_TK_RD   = 6'b001000,
    S_TK_CMP  = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == AW'(QUEUE_DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? AW'(QUEUE_DEPTH - 1) : i - AW'(1);
  endfunction

  state_t                         state_r, state_nxt;
  logic [TW-1:0]                  tick_r, tick_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [AW-1:0]                  head_r, head_nxt;
  logic [AW-1:0]                  pos_r, pos_nxt;
  logic [CW-1:0]                  left_r, left_nxt;
  logic [sdq_pkg::WAKE_W-1:0]     wakes_r, wakes_nxt;
  logic                           pend_r, pend_nxt;
  logic [sdq_pkg::ID_W-1:0]       pend_id_r, pend_id_nxt;
  sdq_pkg::entry_t                new_r, new_nxt;
  sdq_pkg::out_item_t             res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  sdq_pkg::out_item_t             out_data_r, out_data_nxt;

  logic                           in_xfer;
  logic                           out_free;
  logic [CW:0]                    tail_sum;
  logic [TW:0]                    when_sum;
  logic [TW-1:0]                  cmp_ref;
  logic                           at_or_below;
  logic                           due;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  sdq_pkg::entry_t                wr_entry;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  sdq_pkg::entry_t                rd_entry;

  sdq_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Tail slot and saturated deadline for a new request
  always_comb begin
    tail_sum = {{(CW + 1 - AW){1'b0}}, head_r} + {1'b0, count_r};
    if (tail_sum >= (CW + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CW + 1)'(QUEUE_DEPTH);
    end
    when_sum = {1'b0, tick_r} + (TW + 1)'(unsigned'(in_data.sleep_ticks));
  end

  // Shared compare: stored wake time against the new deadline or the count
  assign cmp_ref     = (state_r == S_INS_CMP) ? new_r.wake_time : tick_r;
  assign at_or_below = (rd_entry.wake_time <= cmp_ref);

  // Front entry is due on this tick
  assign due = (count_r != '0) && (wakes_r < sdq_pkg::WAKE_W'(sdq_pkg::MAX_WAKES))
               && at_or_below;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    pos_nxt       = pos_r;
    left_nxt      = left_r;
    wakes_nxt     = wakes_r;
    pend_nxt      = pend_r;
    pend_id_nxt   = pend_id_r;
    new_nxt       = new_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_entry      = new_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.func == sdq_pkg::FUNC_SLEEP) begin
            res_nxt = '{kind: sdq_pkg::KIND_ACCEPTED, woken_id: in_data.sleeper_id,
                        tick_count: tick_r, last: 1'b1};
            new_nxt.id        = in_data.sleeper_id;
            new_nxt.wake_time = when_sum[TW] ? {TW{1'b1}} : when_sum[TW-1:0];
            pos_nxt           = tail_sum[AW-1:0];
            left_nxt          = count_r;
            if (in_data.sleep_ticks[sdq_pkg::DUR_W-1] || (in_data.sleep_ticks == '0)) begin
              res_nxt.kind     = sdq_pkg::KIND_IGNORED;
              res_nxt.woken_id = '0;
              state_nxt        = S_FIN;
            end else if (count_r == CW'(QUEUE_DEPTH)) begin
              res_nxt.kind     = sdq_pkg::KIND_FULL;
              res_nxt.woken_id = '0;
              state_nxt        = S_FIN;
            end else begin
              state_nxt = S_INS_RD;
            end
          end else begin
            if (tick_r != {TW{1'b1}}) begin
              tick_nxt = tick_r + TW'(1);
            end
            wakes_nxt = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_TK_RD;
          end
        end
      end

      // Look at the entry before the open slot, or drop the new one in
      S_INS_RD: begin
        if (left_r == '0) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_dec(pos_r);
          state_nxt = S_INS_CMP;
        end
      end

      // Shift a later entry back one slot, or place the new entry
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (!at_or_below) begin
          wr_entry  = rd_entry;
          pos_nxt   = idx_dec(pos_r);
          left_nxt  = left_r - CW'(1);
          state_nxt = S_INS_RD;
        end else begin
          count_nxt = count_r + CW'(1);
          state_nxt = S_FIN;
        end
      end

      S_TK_RD: begin
        rd_en     = 1'b1;
        rd_addr   = head_r;
        state_nxt = S_TK_CMP;
      end

      // Pop a due sleeper; the previous one goes out without last
      S_TK_CMP: begin
        if (due) begin
          if (!pend_r || out_free) begin
            if (pend_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{kind: sdq_pkg::KIND_WOKEN, woken_id: pend_id_r,
                                tick_count: tick_r, last: 1'b0};
            end
            pend_nxt    = 1'b1;
            pend_id_nxt = rd_entry.id;
            head_nxt    = idx_inc(head_r);
            count_nxt   = count_r - CW'(1);
            wakes_nxt   = wakes_r + sdq_pkg::WAKE_W'(1);
            state_nxt   = S_TK_RD;
          end
        end else begin
          if (pend_r) begin
            res_nxt = '{kind: sdq_pkg::KIND_WOKEN, woken_id: pend_id_r,
                        tick_count: tick_r, last: 1'b1};
          end else begin
            res_nxt = '{kind: sdq_pkg::KIND_NO_WAKE, woken_id: '0,
                        tick_count: tick_r, last: 1'b1};
          end
          state_nxt = S_FIN;
        end
      end

      // Hand the final result to the output register
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      count_r     <= '0;
      head_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      wakes_r     <= '0;
      left_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      wakes_r     <= wakes_nxt;
      left_r      <= left_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    pend_id_r  <= pend_id_nxt;
    new_r      <= new_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Occupancy never passes the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  // Tick count never goes backward
  a_tick_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && $past(rst_n) |-> tick_r >= $past(tick_r))
    else $error("tick count decreased");

  // Head moves only when a due sleeper is popped
  a_head_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (head_r != $past(head_r)) |-> $past(state_r == S_TK_CMP))
    else $error("head moved outside a wake step");

  // Occupancy changes by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1))
                     || (count_r == $past(count_r) - CW'(1)))
    else $error("occupancy jumped");

  // Wake count stays within one tick's limit
  a_wake_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wakes_r <= sdq_pkg::WAKE_W'(sdq_pkg::MAX_WAKES))
    else $error("too many wakes on one tick");

endmodule
